// ----- rtl/clip_pkg.sv -----
// shared types and constants of the config line ip parser
package clip_pkg;

    // configuration register indexes
    localparam logic CFG_KEY_TEXT   = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    // result status codes
    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_NO_KEY    = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam int unsigned KEY_BITS     = 64;
    localparam int unsigned KEY_LEN_BITS = 4;
    localparam int unsigned OCTET_MAX    = 255;

    typedef enum logic [2:0] {
        PH_LINE_WS = 3'd0,
        PH_KEY     = 3'd1,
        PH_SKIP    = 3'd2,
        PH_VALUE   = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    // one classified text byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_dot;
        logic       is_eq;
        logic       is_nul;
        logic       is_lf;
        logic       is_blank;
        logic       is_term;
    } item_t;

endpackage

// ----- rtl/clip_front.sv -----
// front stage: takes text bytes and classifies them into a register
module clip_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    output logic                 item_valid,
    input  logic                 item_ready,
    output clip_pkg::item_t      item
);
    import clip_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign s_tready = !valid_reg || item_ready;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.text_byte = s_tdata;
        item_next.digit     = 4'(s_tdata - CH_ZERO);
        item_next.is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
        item_next.is_dot    = (s_tdata == CH_DOT);
        item_next.is_eq     = (s_tdata == CH_EQ);
        item_next.is_nul    = (s_tdata == CH_NUL);
        item_next.is_lf     = (s_tdata == CH_LF);
        item_next.is_blank  = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);
        item_next.is_term   = (s_tdata == CH_NUL) || (s_tdata == CH_CR) ||
                              (s_tdata == CH_LF) || (s_tdata == CH_SPACE) ||
                              (s_tdata == CH_TAB);
        valid_next = load || (valid_reg && !item_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/clip_queue.sv -----
// short queue of classified bytes between front and back
module clip_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  clip_pkg::item_t      push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output clip_pkg::item_t      pop_item
);
    import clip_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    item_t              store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = store[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/clip_back.sv -----
// back stage: line, key and address state machine with result register
module clip_back #(
    parameter int unsigned MAX_KEY_CHARS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [clip_pkg::KEY_BITS-1:0] key_text,
    input  logic [clip_pkg::KEY_LEN_BITS-1:0] key_length,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  clip_pkg::item_t               item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [1:0]                    res_status,
    output logic [31:0]                   res_address
);
    import clip_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  key_pos_reg, key_pos_next;
    logic [7:0]  octet_reg, octet_next;
    logic [1:0]  count_reg, count_next;
    logic        seen_reg, seen_next;
    logic [23:0] upper_reg, upper_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [31:0] out_addr_reg, out_addr_next;

    logic        take;
    logic        emit;
    logic [1:0]  emit_status;
    logic [31:0] emit_addr;
    logic [3:0]  klen;
    logic [3:0]  kpos;
    logic [7:0]  key_char;
    logic [11:0] octet_sum;
    logic        ok;

    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;
    assign klen       = (key_length > 4'(MAX_KEY_CHARS)) ? 4'(MAX_KEY_CHARS) : key_length;
    assign kpos       = (phase_reg == PH_LINE_WS) ? 4'd0 : key_pos_reg;
    assign key_char   = key_text[{kpos[2:0], 3'b000} +: 8];
    assign octet_sum  = {1'b0, octet_reg, 3'b000} + {3'b000, octet_reg, 1'b0} +
                        {8'd0, item.digit};
    assign ok         = item.is_term && seen_reg && (count_reg == 2'd3);

    always_comb begin
        phase_next   = phase_reg;
        key_pos_next = key_pos_reg;
        octet_next   = octet_reg;
        count_next   = count_reg;
        seen_next    = seen_reg;
        upper_next   = upper_reg;
        emit         = 1'b0;
        emit_status  = ST_VALID;
        emit_addr    = '0;

        if (take) begin
            if (phase_reg == PH_VALUE) begin
                if (item.is_digit) begin
                    if (octet_sum > 12'(OCTET_MAX)) begin
                        phase_next  = PH_DONE;
                        emit        = 1'b1;
                        emit_status = ST_MALFORMED;
                    end else begin
                        octet_next = octet_sum[7:0];
                        seen_next  = 1'b1;
                    end
                end else if (item.is_dot) begin
                    if (!seen_reg || count_reg == 2'd3) begin
                        phase_next  = PH_DONE;
                        emit        = 1'b1;
                        emit_status = ST_MALFORMED;
                    end else begin
                        upper_next = {upper_reg[15:0], octet_reg};
                        count_next = count_reg + 2'd1;
                        octet_next = '0;
                        seen_next  = 1'b0;
                    end
                end else begin
                    emit        = 1'b1;
                    emit_status = ok ? ST_VALID : ST_MALFORMED;
                    emit_addr   = ok ? {upper_reg, octet_reg} : 32'd0;
                    if (item.is_nul) begin
                        phase_next   = PH_LINE_WS;
                        key_pos_next = '0;
                        octet_next   = '0;
                        count_next   = '0;
                        seen_next    = 1'b0;
                        upper_next   = '0;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
            end else if (item.is_nul) begin
                // end of buffer: report a missing key unless a result was already reported
                emit         = (phase_reg != PH_DONE);
                emit_status  = ST_NO_KEY;
                phase_next   = PH_LINE_WS;
                key_pos_next = '0;
                octet_next   = '0;
                count_next   = '0;
                seen_next    = 1'b0;
                upper_next   = '0;
            end else begin
                case (phase_reg)
                    PH_SKIP: begin
                        if (item.is_lf) begin
                            phase_next = PH_LINE_WS;
                        end
                    end
                    PH_LINE_WS, PH_KEY: begin
                        if (phase_reg == PH_LINE_WS && item.is_blank) begin
                            phase_next = PH_LINE_WS;
                        end else if (kpos < klen) begin
                            if (item.text_byte == key_char) begin
                                key_pos_next = kpos + 4'd1;
                                phase_next   = PH_KEY;
                            end else begin
                                key_pos_next = '0;
                                phase_next   = item.is_lf ? PH_LINE_WS : PH_SKIP;
                            end
                        end else if (item.is_eq) begin
                            key_pos_next = kpos;
                            phase_next   = PH_VALUE;
                            octet_next   = '0;
                            count_next   = '0;
                            seen_next    = 1'b0;
                            upper_next   = '0;
                        end else begin
                            key_pos_next = '0;
                            phase_next   = item.is_lf ? PH_LINE_WS : PH_SKIP;
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        out_valid_next  = emit || (out_valid_reg && !res_ready);
        out_status_next = emit ? emit_status : out_status_reg;
        out_addr_next   = emit ? emit_addr : out_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LINE_WS;
            key_pos_reg   <= '0;
            octet_reg     <= '0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            upper_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            key_pos_reg   <= key_pos_next;
            octet_reg     <= octet_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign res_valid   = out_valid_reg;
    assign res_status  = out_status_reg;
    assign res_address = out_addr_reg;

endmodule

// ----- rtl/config_line_ip_parser_core.sv -----
// top level of the config line ip parser: finds key=a.b.c.d in a byte stream
// path: the deciding byte passes the front item register and the queue, then sets the result register on m_tvalid
// throughput: one text byte per cycle, unless a result held by m_tready low stalls the back state machine
// a full result register back-pressures through the four-entry queue to s_tready
// reset: aresetn synchronous active low; clears parser state, queue and key registers
// no clearing pass: bytes are taken from the first cycle after reset
module config_line_ip_parser_core #(
    parameter int unsigned MAX_KEY_CHARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    // text byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] text_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata      // [1:0] status, [33:2] address, [39:34] zero
);
    import clip_pkg::*;

    // configuration registers
    logic [KEY_BITS-1:0]     key_text_reg;
    logic [KEY_BITS-1:0]     key_text_next;
    logic [KEY_LEN_BITS-1:0] key_length_reg;
    logic [KEY_LEN_BITS-1:0] key_length_next;

    // front to queue
    logic  f_valid;
    logic  f_ready;
    item_t f_item;

    // queue to back
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    logic [1:0]  res_status;
    logic [31:0] res_address;

    always_comb begin
        key_text_next   = key_text_reg;
        key_length_next = key_length_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KEY_TEXT:   key_text_next   = cfg_data;
                CFG_KEY_LENGTH: key_length_next = cfg_data[KEY_LEN_BITS-1:0];
                default:        key_text_next   = key_text_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_text_reg   <= '0;
            key_length_reg <= '0;
        end else begin
            key_text_reg   <= key_text_next;
            key_length_reg <= key_length_next;
        end
    end

    // front: register and classify each byte
    clip_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // decoupling queue so a stalled result does not stall the input at once
    clip_queue #(
        .DEPTH (4)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // back: key match, octet parsing and result register
    clip_back #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .key_text    (key_text_reg),
        .key_length  (key_length_reg),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_status  (res_status),
        .res_address (res_address)
    );

    assign m_tdata = {6'd0, res_address, res_status};

endmodule

// ----- test/config_line_ip_parser_checker.sv -----
// checker for the config line ip parser: predicts every result and compares the result stream
`timescale 1ns / 100ps

module config_line_ip_parser_checker #(
    parameter int unsigned MAX_KEY_CHARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] text_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,      // [1:0] status, [33:2] address, [39:34] zero
    output int unsigned mismatches,
    output int unsigned results_due
);
    import clip_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } ip_result_t;

    ip_result_t  due_results[$];

    // shadow of the key registers
    logic [63:0] key_text;
    logic [3:0]  key_length;

    // parser state
    phase_t      phase;
    logic [3:0]  key_pos;
    logic [7:0]  octet_val;
    logic [1:0]  octet_cnt;
    logic        digit_seen;
    logic [23:0] upper_octets;

    initial begin
        mismatches  = 0;
        results_due = 0;
    end

    function automatic void clear_line();
        phase        = PH_LINE_WS;
        key_pos      = '0;
        octet_val    = '0;
        octet_cnt    = '0;
        digit_seen   = 1'b0;
        upper_octets = '0;
    endfunction

    function automatic void predict_result(input logic [1:0] st, input logic [31:0] addr);
        due_results.push_back('{status: st, address: addr});
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void parse_text_byte(input logic [7:0] b);
        int unsigned klen;
        int unsigned next_val;
        logic        term;
        logic        compare_key;
        logic [7:0]  key_char;
        klen        = (key_length > MAX_KEY_CHARS) ? MAX_KEY_CHARS : key_length;
        compare_key = 1'b0;
        term        = (b == CH_NUL || b == CH_CR || b == CH_LF || b == CH_SPACE || b == CH_TAB);
        if (phase == PH_VALUE) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                next_val = octet_val * 10 + (b - CH_ZERO);
                if (next_val > OCTET_MAX) begin
                    phase = PH_DONE;
                    predict_result(ST_MALFORMED, '0);
                end else begin
                    octet_val  = next_val[7:0];
                    digit_seen = 1'b1;
                end
            end else if (b == CH_DOT) begin
                if (!digit_seen || octet_cnt == 2'd3) begin
                    phase = PH_DONE;
                    predict_result(ST_MALFORMED, '0);
                end else begin
                    upper_octets = {upper_octets[15:0], octet_val};
                    octet_cnt    = octet_cnt + 2'd1;
                    octet_val    = '0;
                    digit_seen   = 1'b0;
                end
            end else begin
                if (term && digit_seen && octet_cnt == 2'd3)
                    predict_result(ST_VALID, {upper_octets, octet_val});
                else
                    predict_result(ST_MALFORMED, '0);
                if (b == CH_NUL)
                    clear_line();
                else
                    phase = PH_DONE;
            end
        end else if (b == CH_NUL) begin
            if (phase != PH_DONE)
                predict_result(ST_NO_KEY, '0);
            clear_line();
        end else begin
            case (phase)
                PH_LINE_WS: begin
                    if (b != CH_SPACE && b != CH_TAB) begin
                        phase       = PH_KEY;
                        key_pos     = '0;
                        compare_key = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (b == CH_LF)
                        phase = PH_LINE_WS;
                end
                PH_KEY:  compare_key = 1'b1;
                default: ;
            endcase
            if (compare_key) begin
                key_char = key_text[8 * key_pos[2:0] +: 8];
                if (key_pos < klen && b == key_char) begin
                    key_pos = key_pos + 4'd1;
                end else if (key_pos >= klen && b == CH_EQ) begin
                    phase        = PH_VALUE;
                    octet_val    = '0;
                    octet_cnt    = '0;
                    digit_seen   = 1'b0;
                    upper_octets = '0;
                end else begin
                    key_pos = '0;
                    phase   = (b == CH_LF) ? PH_LINE_WS : PH_SKIP;
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        ip_result_t want;
        if (!aresetn) begin
            key_text   = '0;
            key_length = '0;
            clear_line();
            due_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_KEY_TEXT)
                    key_text = cfg_data;
                else
                    key_length = cfg_data[KEY_LEN_BITS-1:0];
            end
            // results are compared before the byte of this edge, which cannot cause one yet
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status %0d address %h",
                                              m_tdata[1:0], m_tdata[33:2]));
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[1:0] != want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  m_tdata[1:0], want.status));
                    if (m_tdata[33:2] != want.address)
                        report_mismatch($sformatf("address %h, predicted %h",
                                                  m_tdata[33:2], want.address));
                end
                if (m_tdata[39:34] != '0)
                    report_mismatch($sformatf("padding bits %h not zero", m_tdata[39:34]));
            end
            if (s_tvalid && s_tready)
                parse_text_byte(s_tdata);
        end
        results_due = due_results.size();
    end

endmodule

// ----- test/config_line_ip_parser_core_tb.sv -----
// testbench top of the config line ip parser: text buffer stimulus, key settings and verdict
`timescale 1ns / 100ps

module config_line_ip_parser_core_tb;
    import clip_pkg::*;

    localparam int unsigned MAX_KEY_CHARS = 8;
    localparam int unsigned RANDOM_BYTES  = 1330;
    localparam int unsigned CALM_AFTER    = 1130;    // no idling once this many random bytes went
    localparam int unsigned SETTLE_CYCLES = 10;      // covers the pipeline latency and the queue
    localparam int unsigned CYCLE_LIMIT   = 500_000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] text_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;      // [1:0] status, [33:2] address, [39:34] zero

    int unsigned mismatches;
    int unsigned results_due;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent  = 0;

    // idling switches for the text sender and the result receiver
    logic        tx_idle_on = 1'b1;
    logic        rx_idle_on = 1'b1;

    // key as last written, used to build matching lines
    logic [63:0] key_text_now;
    logic [3:0]  key_len_now;

    // bytes of the buffer being built
    logic [7:0]  text_q[$];

    config_line_ip_parser_core #(
        .MAX_KEY_CHARS(MAX_KEY_CHARS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    config_line_ip_parser_checker #(
        .MAX_KEY_CHARS(MAX_KEY_CHARS)
    ) results_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .results_due(results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // hard stop in case a result never shows
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result receiver: stall bursts at random while idling is on
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- buffer building

    function automatic void add(input logic [7:0] b);
        text_q.push_back(b);
    endfunction

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    // leading blanks of a line, spaces and tabs mixed
    function automatic void add_blanks();
        repeat ($urandom_range(0, 3))
            add($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endfunction

    // key characters in use; lengths above the limit count as the limit
    function automatic int unsigned key_chars_used();
        return (key_len_now > MAX_KEY_CHARS) ? MAX_KEY_CHARS : key_len_now;
    endfunction

    function automatic void add_key();
        for (int i = 0; i < key_chars_used(); i++)
            add(key_text_now[8 * i +: 8]);
    endfunction

    // extremes are favoured
    function automatic int unsigned rand_octet();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return OCTET_MAX;
            default: return $urandom_range(0, OCTET_MAX);
        endcase
    endfunction

    // decimal octet text, now and then with leading zeros
    function automatic void add_octet(input int unsigned v);
        if ($urandom_range(0, 5) == 0)
            add_str($sformatf("%03d", v));
        else
            add_str($sformatf("%0d", v));
    endfunction

    // a line that should not match: blank, near miss on the key, or random text
    function automatic void add_junk_line();
        int unsigned k;
        add_blanks();
        case ($urandom_range(0, 3))
            0: begin
                k = $urandom_range(0, key_chars_used());
                for (int i = 0; i < k; i++)
                    add(key_text_now[8 * i +: 8]);
                add(8'($urandom_range(8'h21, 8'h7E)));
            end
            1: repeat ($urandom_range(0, 10)) add(8'($urandom_range(8'h21, 8'h7E)));
            2: repeat ($urandom_range(1, 6)) add(8'($urandom_range(1, 255)));
            default: ;
        endcase
        add(CH_LF);
    endfunction

    // value terminator, then ignored trailing bytes and the end of the buffer
    function automatic void add_tail();
        logic [7:0] term;
        case ($urandom_range(0, 4))
            0:       term = CH_NUL;
            1:       term = CH_CR;
            2:       term = CH_LF;
            3:       term = CH_SPACE;
            default: term = CH_TAB;
        endcase
        add(term);
        if (term != CH_NUL) begin
            repeat ($urandom_range(0, 5)) add(8'($urandom_range(1, 255)));
            add(CH_NUL);
        end
    endfunction

    // ---------------------------------------------------------------- bus side

    // one text byte transfer, after an optional idle burst
    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() != 0)
            send_byte(text_q.pop_front());
    endtask

    // whole buffer from a string, ended by the zero byte
    task automatic buffer(input string s);
        add_str(s);
        add(CH_NUL);
        send_text();
    endtask

    // hold the sender until every predicted result has come and the block is quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both key registers, back to back; upper data bits of the length write are noise
    task automatic set_key(input logic [63:0] text, input logic [3:0] len);
        logic [63:0] noise;
        noise     = {$urandom, $urandom};
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_KEY_TEXT;
        cfg_data  <= text;
        @(posedge aclk);
        cfg_index <= CFG_KEY_LENGTH;
        cfg_data  <= {noise[63:KEY_LEN_BITS], len};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        key_text_now = text;
        key_len_now  = len;
    endtask

    // ---------------------------------------------------------------- stimulus

    initial begin
        int unsigned start_bytes;
        int unsigned buf_count;
        int unsigned kind;
        int unsigned bad;
        int unsigned pos;
        int unsigned n_oct;
        logic [63:0] new_text;
        logic [3:0]  new_len;
        logic [7:0]  c;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_KEY_TEXT;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        key_text_now = '0;
        key_len_now  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty key after reset: empty buffer, then '=' first on the line
        buffer("");
        buffer(" \t=0.0.0.0");

        drain();
        set_key(64'h7069, 4'd2);                    // "ip"
        buffer("ip=255.255.255.255\n");
        add_str("ip=1.2.3.4");
        add(CH_CR);
        add(CH_NUL);
        send_text();
        buffer("ip=10.0.0.1 trailing=junk");        // bytes after the result are ignored
        buffer("\tip=192.168.001.20\tx");
        buffer("ip=256.1.1.1");                     // octet above 255
        buffer("ip=.1.2.3");                        // dot without a digit
        buffer("ip=1.2.3.4.5");                     // fourth dot
        buffer("ip=1.2");                           // value cut by the end of the buffer
        buffer("ip=1.2.3.x");                       // stray byte in the value
        buffer("ip=1.2.3\nip=4.5.6.7");             // only the first matching line counts
        buffer("xip=1.1.1.1\n  ip=9.8.7.6");        // mismatching line skipped to newline
        buffer("i\nip=1.1.1.1");                    // mismatch on the newline itself
        buffer("no key here\n");
        add(8'hFF);
        add(8'h80);
        add(CH_LF);
        add_str("ip=0.0.0.1");
        add(CH_NUL);
        send_text();

        // key changed while a buffer is half way through the key
        add_str("ip");
        send_text();
        drain();
        set_key(64'h71_7069, 4'd3);                 // "ipq"
        buffer("q=1.2.3.4");

        // key length beyond the limit counts as the limit
        drain();
        set_key(64'h6867_6665_6463_6261, 4'd15);    // "abcdefgh"
        buffer("abcdefgh=8.8.4.4");

        // newline inside the key, matched across lines
        drain();
        set_key(64'h62_0A_61, 4'd3);
        buffer("a\nb=5.6.7.8");

        // zero byte inside the key can never match
        drain();
        set_key(64'h62_00_61, 4'd3);
        buffer("a");

        // all-ones key
        drain();
        set_key('1, 4'd8);
        repeat (8) add(8'hFF);
        add_str("=100.200.250.255");
        add(CH_NUL);
        send_text();

        // random buffers, a fresh key every eight of them
        start_bytes = bytes_sent;
        buf_count   = 0;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (buf_count % 8 == 0) begin
                drain();
                case ($urandom_range(0, 9))
                    0:       new_len = 4'd0;
                    1:       new_len = 4'($urandom_range(MAX_KEY_CHARS + 1, 15));
                    2:       new_len = 4'(MAX_KEY_CHARS);
                    default: new_len = 4'($urandom_range(1, MAX_KEY_CHARS));
                endcase
                for (int i = 0; i < 8; i++) begin
                    if ($urandom_range(0, 39) == 0)
                        c = CH_NUL;
                    else if ($urandom_range(0, 9) == 0)
                        c = 8'($urandom_range(1, 255));
                    else
                        c = 8'($urandom_range(8'h61, 8'h7A));
                    new_text[8 * i +: 8] = c;
                end
                set_key(new_text, new_len);
            end

            // idling comes and goes, and stops for the last stretch
            if (bytes_sent - start_bytes > CALM_AFTER) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end

            kind = $urandom_range(0, 99);
            if (kind >= 90) begin
                // noise
                repeat ($urandom_range(1, 12)) add(8'($urandom_range(1, 255)));
                add(CH_NUL);
            end else if (kind >= 80) begin
                // no key line at all
                repeat ($urandom_range(1, 3)) add_junk_line();
                add(CH_NUL);
            end else begin
                repeat ($urandom_range(0, 2)) add_junk_line();
                add_blanks();
                add_key();
                add(CH_EQ);
                if (kind < 55) begin
                    for (int i = 0; i < 4; i++) begin
                        if (i != 0)
                            add(CH_DOT);
                        add_octet(rand_octet());
                    end
                end else begin
                    // broken value: big octet, empty octet, five octets, too few, stray byte
                    bad   = $urandom_range(0, 4);
                    pos   = $urandom_range(0, 3);
                    n_oct = (bad == 2) ? 5 : (bad == 3) ? $urandom_range(0, 3) : 4;
                    for (int i = 0; i < n_oct; i++) begin
                        if (i != 0)
                            add(CH_DOT);
                        if (bad == 0 && i == pos)
                            add_octet($urandom_range(OCTET_MAX + 1, 999));
                        else if (!(bad == 1 && i == pos))
                            add_octet(rand_octet());
                        if (bad == 4 && i == pos) begin
                            do c = 8'($urandom_range(1, 255));
                            while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT ||
                                   c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF);
                            add(c);
                        end
                    end
                end
                add_tail();
            end
            send_text();
            buf_count++;
        end

        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/clip_pkg.sv
rtl/clip_front.sv
rtl/clip_queue.sv
rtl/clip_back.sv
rtl/config_line_ip_parser_core.sv
test/config_line_ip_parser_checker.sv
test/config_line_ip_parser_core_tb.sv
